// ===== src/tbt_pkg.sv =====
`default_nettype none

package tbt_pkg;

	localparam int CMD_W    = 3;
	localparam int BUCKET_W = 6;
	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 2;

	localparam int NUM_BUCKETS_DEF = 64;
	localparam int TOKEN_BITS_DEF  = 16;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FETCH  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RETURN = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [BUCKET_W-1:0] bucket;
		logic [FIELD_W-1:0]  amount;
		logic [FIELD_W-1:0]  refill_rate;
		logic [FIELD_W-1:0]  capacity;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [BUCKET_W-1:0] bucket_out;
		logic [FIELD_W-1:0]  granted;
	} rsp_t;

endpackage

`default_nettype wire

// ===== src/tbt_mem.sv =====
`default_nettype none

module tbt_mem import tbt_pkg::*; #(
	parameter int DEPTH = NUM_BUCKETS_DEF,
	parameter int WIDTH = 1 + TOKEN_BITS_DEF + 2 * FIELD_W
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tbt_alu.sv =====
`default_nettype none

module tbt_alu import tbt_pkg::*; #(
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  wire logic [CMD_W-1:0]      cmd,
	input  wire logic [TOKEN_BITS-1:0] count,
	input  wire logic [FIELD_W-1:0]    rate,
	input  wire logic [FIELD_W-1:0]    cap,
	input  wire logic [FIELD_W-1:0]    amount,
	output      logic [TOKEN_BITS-1:0] count_nxt,
	output      logic [FIELD_W-1:0]    granted
);

	localparam int LW = (TOKEN_BITS > FIELD_W) ? TOKEN_BITS : FIELD_W;
	localparam int SW = LW + 1;

	logic [LW-1:0]         count_w;
	logic [LW-1:0]         cap_w;
	logic [LW-1:0]         amount_w;
	logic [LW-1:0]         addend_w;
	logic [LW-1:0]         max_w;
	logic [TOKEN_BITS-1:0] lim;
	logic [SW-1:0]         sum;

	always_comb begin
		count_w  = LW'(count);
		cap_w    = LW'(cap);
		amount_w = LW'(amount);
		addend_w = (cmd == CMD_TICK) ? LW'(rate) : amount_w;
		max_w    = LW'({TOKEN_BITS{1'b1}});
		lim      = (cap_w >= max_w) ? {TOKEN_BITS{1'b1}} : TOKEN_BITS'(cap_w);
		sum      = SW'(count_w) + SW'(addend_w);
		if (cmd == CMD_FETCH) begin
			if (count_w >= amount_w) begin
				count_nxt = TOKEN_BITS'(count_w - amount_w);
				granted   = amount;
			end else begin
				count_nxt = '0;
				granted   = FIELD_W'(count_w);
			end
		end else begin
			count_nxt = (sum >= SW'(lim)) ? lim : TOKEN_BITS'(sum);
			granted   = '0;
		end
	end

endmodule

`default_nettype wire

// ===== src/token_bucket_table.sv =====
`default_nettype none

// channel | role   | handshake            | payload
// req     | input  | req_valid, req_stall | req (req_t)
// rsp     | output | rsp_valid, rsp_stall | rsp (rsp_t)
//
// Free, fetch and return do one bucket memory read, then a write-back if the
// bucket is allocated; unknown commands only read. Allocate reads from index
// 0 to the first free bucket; tick walks all NUM_BUCKETS entries, one memory
// entry per cycle. A clearing pass over every entry after reset holds
// req_stall high. One command at a time; a held result register lets the next
// transfer in while rsp_stall is high, and a finishing command waits for it.

module token_bucket_table import tbt_pkg::*; #(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int TOKEN_BITS  = TOKEN_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output      logic req_stall,
	input  wire req_t req,
	output      logic rsp_valid,
	input  wire logic rsp_stall,
	output      rsp_t rsp
);

	localparam int IDX_W = $clog2(NUM_BUCKETS);
	localparam int CW    = ((IDX_W > BUCKET_W) ? IDX_W : BUCKET_W) + 1;
	localparam int EW    = 1 + TOKEN_BITS + 2 * FIELD_W;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_OP    = 3'd2;
	localparam logic [2:0] S_ALLOC = 3'd3;
	localparam logic [2:0] S_TICK  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] ptr_q;
	req_t             req_q;
	logic [IDX_W-1:0] idx_q;
	logic             in_range_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             accept;
	logic             slot_free;
	logic             ptr_last;
	logic             tick_go;
	logic             alloc_adv;
	logic             entry_ok;
	logic             op_needs;

	logic             re;
	logic [IDX_W-1:0] raddr;
	logic [EW-1:0]    rdata;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [EW-1:0]    wdata;

	logic                  rd_used;
	logic [TOKEN_BITS-1:0] rd_count;
	logic [FIELD_W-1:0]    rd_rate;
	logic [FIELD_W-1:0]    rd_cap;
	logic [TOKEN_BITS-1:0] count_nxt;
	logic [FIELD_W-1:0]    alu_granted;

	logic             fin;
	rsp_t             fin_rsp;
	logic [2:0]       state_d;

	assign rd_cap   = rdata[FIELD_W-1:0];
	assign rd_rate  = rdata[2*FIELD_W-1:FIELD_W];
	assign rd_count = rdata[2*FIELD_W +: TOKEN_BITS];
	assign rd_used  = rdata[EW-1];

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign ptr_last  = (ptr_q == IDX_W'(NUM_BUCKETS - 1));
	assign tick_go   = !ptr_last || slot_free;
	assign alloc_adv = rd_used && !ptr_last;
	assign entry_ok  = in_range_q && rd_used;
	assign op_needs  = (req_q.cmd == CMD_FREE) || (req_q.cmd == CMD_FETCH) ||
		(req_q.cmd == CMD_RETURN);

	tbt_mem #(
		.DEPTH(NUM_BUCKETS),
		.WIDTH(EW)
	) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	tbt_alu #(
		.TOKEN_BITS(TOKEN_BITS)
	) u_alu (
		.cmd      (req_q.cmd),
		.count    (rd_count),
		.rate     (rd_rate),
		.cap      (rd_cap),
		.amount   (req_q.amount),
		.count_nxt(count_nxt),
		.granted  (alu_granted)
	);

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q + IDX_W'(1);
		we    = 1'b0;
		waddr = ptr_q;
		wdata = {1'b1, count_nxt, rd_rate, rd_cap};
		fin   = 1'b0;
		fin_rsp.status     = ST_OK;
		fin_rsp.bucket_out = req_q.bucket;
		fin_rsp.granted    = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				we    = 1'b1;
				wdata = '0;
				if (ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					re = 1'b1;
					if (req.cmd == CMD_ALLOC) begin
						raddr   = '0;
						state_d = S_ALLOC;
					end else if (req.cmd == CMD_TICK) begin
						raddr   = '0;
						state_d = S_TICK;
					end else begin
						raddr   = IDX_W'(req.bucket);
						state_d = S_OP;
					end
				end
			end
			S_OP: begin
				waddr = idx_q;
				if (slot_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (op_needs && !entry_ok) begin
						fin_rsp.status = ST_NOT_ALLOC;
					end else if (op_needs) begin
						we = 1'b1;
						if (req_q.cmd == CMD_FREE) begin
							wdata = {1'b0, rdata[EW-2:0]};
						end
						if (req_q.cmd == CMD_FETCH) begin
							fin_rsp.granted = alu_granted;
						end
					end
				end
			end
			S_ALLOC: begin
				wdata = {1'b1, {TOKEN_BITS{1'b0}}, req_q.refill_rate, req_q.capacity};
				if (alloc_adv) begin
					re = 1'b1;
				end else if (slot_free) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (!rd_used) begin
						we = 1'b1;
						fin_rsp.bucket_out = BUCKET_W'(ptr_q);
					end else begin
						fin_rsp.status     = ST_FULL;
						fin_rsp.bucket_out = '0;
					end
				end
			end
			S_TICK: begin
				if (tick_go) begin
					we = rd_used;
					if (ptr_last) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						re = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept || state_d == S_IDLE) begin
				ptr_q <= '0;
			end else if ((state_q == S_CLR) || (state_q == S_ALLOC && alloc_adv) ||
				(state_q == S_TICK && tick_go)) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q      <= req;
			idx_q      <= IDX_W'(req.bucket);
			in_range_q <= (CW'(req.bucket) < CW'(NUM_BUCKETS));
		end
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_op_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OP && slot_free) |=> (state_q == S_IDLE))
		else $error("single-entry command did not finish");

	a_tick_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && tick_go && !ptr_last) |=>
		(state_q == S_TICK && ptr_q == $past(ptr_q) + IDX_W'(1)))
		else $error("tick walk skipped an entry");

	a_grant_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && fin_rsp.granted != '0) |-> (req_q.cmd == CMD_FETCH))
		else $error("tokens granted by a command other than fetch");

	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> slot_free)
		else $error("result overwrote a held transfer");

endmodule

`default_nettype wire

// ===== sim/token_bucket_table_tb.sv =====
`default_nettype none

module token_bucket_table_tb;
	import tbt_pkg::*;

	localparam int NB           = NUM_BUCKETS_DEF;
	localparam int HOLD_CYCLES  = 220;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 80;

	localparam logic [CMD_W-1:0] CMD_BAD_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_BAD_LAST  = 3'd7;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic              bkt_live   [NB] = '{default: 1'b0};
	logic [FIELD_W-1:0] bkt_tokens [NB] = '{default: '0};
	logic [FIELD_W-1:0] bkt_rate   [NB] = '{default: '0};
	logic [FIELD_W-1:0] bkt_cap    [NB] = '{default: '0};
	int                live_cnt = 0;

	rsp_t want_rsp_q [$];
	rsp_t want_rsp;

	int err_cnt      = 0;
	int req_cnt      = 0;
	int rsp_cnt      = 0;
	int full_cnt     = 0;
	int partial_cnt  = 0;
	int cmd_cnt [8]  = '{default: 0};
	int idle_cycles  = 0;
	bit quiet        = 1'b0;
	bit hold_rsp     = 1'b0;
	bit hold_active  = 1'b0;

	token_bucket_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [FIELD_W-1:0] clamp_add(logic [FIELD_W-1:0] cnt,
			logic [FIELD_W-1:0] add, logic [FIELD_W-1:0] lim);
		logic [FIELD_W:0] sum;
		sum = {1'b0, cnt} + {1'b0, add};
		return (sum >= {1'b0, lim}) ? lim : sum[FIELD_W-1:0];
	endfunction

	function automatic rsp_t bucket_table_apply(req_t r);
		rsp_t o;
		logic hit;
		o.status     = ST_OK;
		o.bucket_out = r.bucket;
		o.granted    = '0;
		hit = bkt_live[r.bucket];
		case (r.cmd)
			CMD_ALLOC: begin
				o.status     = ST_FULL;
				o.bucket_out = '0;
				for (int i = 0; i < NB; i++) begin
					if (!bkt_live[i]) begin
						bkt_live[i]   = 1'b1;
						bkt_tokens[i] = '0;
						bkt_rate[i]   = r.refill_rate;
						bkt_cap[i]    = r.capacity;
						o.status      = ST_OK;
						o.bucket_out  = i[BUCKET_W-1:0];
						live_cnt++;
						break;
					end
				end
				if (o.status == ST_FULL)
					full_cnt++;
			end
			CMD_FREE: begin
				if (hit) begin
					bkt_live[r.bucket] = 1'b0;
					live_cnt--;
				end else
					o.status = ST_NOT_ALLOC;
			end
			CMD_TICK: begin
				for (int i = 0; i < NB; i++)
					if (bkt_live[i])
						bkt_tokens[i] = clamp_add(bkt_tokens[i], bkt_rate[i], bkt_cap[i]);
			end
			CMD_FETCH: begin
				if (!hit)
					o.status = ST_NOT_ALLOC;
				else if (bkt_tokens[r.bucket] >= r.amount) begin
					bkt_tokens[r.bucket] -= r.amount;
					o.granted = r.amount;
				end else begin
					o.granted = bkt_tokens[r.bucket];
					bkt_tokens[r.bucket] = '0;
					partial_cnt++;
				end
			end
			CMD_RETURN: begin
				if (hit)
					bkt_tokens[r.bucket] = clamp_add(bkt_tokens[r.bucket], r.amount,
						bkt_cap[r.bucket]);
				else
					o.status = ST_NOT_ALLOC;
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic int pick_gap();
		int p;
		if (quiet)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(logic [CMD_W-1:0] cmd, int b, int amt, int rate, int cap);
		req_t r;
		r.cmd         = cmd;
		r.bucket      = b[BUCKET_W-1:0];
		r.amount      = amt[FIELD_W-1:0];
		r.refill_rate = rate[FIELD_W-1:0];
		r.capacity    = cap[FIELD_W-1:0];
		return r;
	endfunction

	function automatic req_t rand_bucket_cmd();
		req_t r;
		int p;
		r = make_req(CMD_FETCH, $urandom_range(0, NB - 1), $urandom_range(0, 16'hFFFF),
			$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
		p = $urandom_range(0, 99);
		if (p < 12)
			r.cmd = CMD_ALLOC;
		else if (p < 24)
			r.cmd = CMD_FREE;
		else if (p < 32)
			r.cmd = CMD_TICK;
		else if (p < 67)
			r.cmd = CMD_FETCH;
		else if (p < 96)
			r.cmd = CMD_RETURN;
		else
			r.cmd = CMD_BAD_FIRST + CMD_W'($urandom_range(0, CMD_BAD_LAST - CMD_BAD_FIRST));
		if (live_cnt > 0 && $urandom_range(0, 9) < 8)
			while (!bkt_live[r.bucket])
				r.bucket = BUCKET_W'($urandom_range(0, NB - 1));
		case ($urandom_range(0, 3))
			0: r.amount = FIELD_W'($urandom_range(0, 300));
			1: r.amount = bkt_tokens[r.bucket];
			2: r.amount = bkt_tokens[r.bucket] + 1'b1;
			default: ;
		endcase
		case ($urandom_range(0, 3))
			0: r.capacity = FIELD_W'($urandom_range(0, 1000));
			1: r.capacity = '1;
			default: ;
		endcase
		if ($urandom_range(0, 1))
			r.refill_rate = FIELD_W'($urandom_range(0, 200));
		return r;
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		want_rsp_q.push_back(bucket_table_apply(r));
		cmd_cnt[r.cmd]++;
		req_cnt++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (want_rsp_q.size() != 0);
	endtask

	task automatic test_directed();
		send_req(make_req(CMD_FETCH, 0, 16'hFFFF, 0, 0));
		send_req(make_req(CMD_FREE, NB - 1, 0, 0, 0));
		send_req(make_req(CMD_RETURN, 5, 1, 0, 0));
		send_req(make_req(CMD_BAD_FIRST, NB - 1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_req(make_req(CMD_W'(CMD_BAD_FIRST + 1), 21, 16'h5555, 16'hAAAA, 16'h5555));
		send_req(make_req(CMD_BAD_LAST, 42, 16'hAAAA, 16'h5555, 16'hAAAA));
		send_req(make_req(CMD_TICK, 7, 0, 0, 0));
		send_req(make_req(CMD_ALLOC, 0, 0, 16'hFFFF, 16'hFFFF));
		send_req(make_req(CMD_ALLOC, 0, 0, 0, 0));
		send_req(make_req(CMD_ALLOC, 0, 0, 100, 250));
		repeat (3)
			send_req(make_req(CMD_TICK, NB - 1, 0, 0, 0));
		send_req(make_req(CMD_FETCH, 0, 16'hFFFF, 0, 0));
		send_req(make_req(CMD_FETCH, 2, 0, 0, 0));
		send_req(make_req(CMD_FETCH, 2, 300, 0, 0));
		send_req(make_req(CMD_RETURN, 2, 16'hFFFF, 0, 0));
		send_req(make_req(CMD_RETURN, 1, 5, 0, 0));
		send_req(make_req(CMD_FETCH, 1, 1, 0, 0));
		send_req(make_req(CMD_FREE, 1, 0, 0, 0));
		send_req(make_req(CMD_FREE, 1, 0, 0, 0));
		send_req(make_req(CMD_ALLOC, 0, 0, 16'h00FF, 16'hFF00));
	endtask

	task automatic test_table_full();
		int b;
		repeat (NB + 2)
			send_req(make_req(CMD_ALLOC, 0, 0, $urandom_range(0, 16'hFFFF),
				$urandom_range(0, 16'hFFFF)));
		send_req(make_req(CMD_TICK, 0, 0, 0, 0));
		send_req(make_req(CMD_FETCH, NB - 1, $urandom_range(0, 16'hFFFF), 0, 0));
		send_req(make_req(CMD_RETURN, NB - 1, 16'hFFFF, 0, 0));
		repeat (NB / 2) begin
			b = $urandom_range(0, NB - 1);
			send_req(make_req(CMD_FREE, b, 0, 0, 0));
		end
		send_req(make_req(CMD_FREE, NB - 1, 0, 0, 0));
	endtask

	task automatic test_random(input int n);
		repeat (n)
			send_req(rand_bucket_cmd());
	endtask

	task automatic test_back_to_back(input int n);
		quiet = 1'b1;
		test_random(n);
		quiet = 1'b0;
	endtask

	task automatic test_rsp_hold();
		req_valid <= 1'b0;
		quiet    = 1'b1;
		hold_rsp = 1'b1;
		while (!hold_active)
			@(posedge clk);
		test_random(24);
		quiet = 1'b0;
		wait_drained();
	endtask

	task automatic test_sender_pause();
		repeat (4) begin
			test_random(10);
			wait_drained();
		end
	endtask

	initial begin : rsp_pacing
		int stall_len;
		int run_len;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp  = 1'b0;
				stall_len = HOLD_CYCLES;
			end else
				stall_len = pick_gap();
			run_len = quiet ? 16 : $urandom_range(1, 12);
			if (stall_len > 0) begin
				rsp_stall   <= 1'b1;
				hold_active = (stall_len == HOLD_CYCLES);
				repeat (stall_len) @(posedge clk);
				hold_active = 1'b0;
				rsp_stall   <= 1'b0;
			end
			repeat (run_len - 1) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_cnt++;
			if (want_rsp_q.size() == 0) begin
				$error("unexpected transfer: status %0d bucket_out %0d granted %0d",
					rsp.status, rsp.bucket_out, rsp.granted);
				err_cnt++;
			end else begin
				want_rsp = want_rsp_q.pop_front();
				if (rsp.status !== want_rsp.status) begin
					$error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
					err_cnt++;
				end
				if (rsp.bucket_out !== want_rsp.bucket_out) begin
					$error("bucket_out: expected %0d, got %0d", want_rsp.bucket_out,
						rsp.bucket_out);
					err_cnt++;
				end
				if (rsp.granted !== want_rsp.granted) begin
					$error("granted: expected %0d, got %0d", want_rsp.granted, rsp.granted);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_table_full();
		test_random(750);
		test_back_to_back(200);
		test_rsp_hold();
		test_sender_pause();
		test_random(550);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests: alloc %0d, free %0d, tick %0d, fetch %0d, return %0d, unknown %0d",
			req_cnt, cmd_cnt[CMD_ALLOC], cmd_cnt[CMD_FREE], cmd_cnt[CMD_TICK],
			cmd_cnt[CMD_FETCH], cmd_cnt[CMD_RETURN],
			cmd_cnt[CMD_BAD_FIRST] + cmd_cnt[CMD_BAD_FIRST + 1] + cmd_cnt[CMD_BAD_LAST]);
		$display("%0d results checked, %0d full-table allocs, %0d partial fetches, %0d errors",
			rsp_cnt, full_cnt, partial_cnt, err_cnt);
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/tbt_pkg.sv
src/tbt_mem.sv
src/tbt_alu.sv
src/token_bucket_table.sv
sim/token_bucket_table_tb.sv
